/* rtl/core/cafu_pkg.sv */
// ----------------------------------------------------------------------------
// cafu_pkg
// Shared types for the 8-bit ALU with flags: request and response items,
// decoded operation and the Z/N/H/C flag set.
// ----------------------------------------------------------------------------
package cafu_pkg;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADC   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SBC   = 5'd3,
		OP_AND   = 5'd4,
		OP_XOR   = 5'd5,
		OP_OR    = 5'd6,
		OP_CP    = 5'd7,
		OP_INC   = 5'd8,
		OP_DEC   = 5'd9,
		OP_RLC   = 5'd10,
		OP_RRC   = 5'd11,
		OP_RL    = 5'd12,
		OP_RR    = 5'd13,
		OP_SLA   = 5'd14,
		OP_SRA   = 5'd15,
		OP_SWAP  = 5'd16,
		OP_SRL   = 5'd17,
		OP_BIT   = 5'd18,
		OP_DAA   = 5'd19,
		OP_CPL   = 5'd20,
		OP_SCF   = 5'd21,
		OP_CCF   = 5'd22,
		OP_ADD16 = 5'd23,
		OP_ADDSP = 5'd24,
		OP_NOP   = 5'd31
	} op_t;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [4:0]  mode;
		logic [7:0]  acc;
		logic [7:0]  value;
		logic [2:0]  bit_index;
		logic        accum_form;
		logic [15:0] wide_base;
		logic [15:0] wide_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  result;
		logic [15:0] wide_result;
		logic        zero_out;
		logic        subtract_out;
		logic        half_out;
		logic        carry_out;
	} out_item_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  acc;
		logic [7:0]  value;
		logic [2:0]  bit_index;
		logic        accum_form;
		logic [15:0] wide_base;
		logic [15:0] wide_value;
	} dec_op_t;

	typedef struct packed {
		logic zero;
		logic subtract;
		logic half;
		logic carry;
	} flags_t;

	// handshake between front and back
	typedef struct packed {
		logic valid;
		logic take;
	} dec_hs_t;

endpackage

/* rtl/core/cafu_front.sv */
// ----------------------------------------------------------------------------
// cafu_front
// Accepts requests, decodes the mode into an operation and holds decoded
// operations in a two-entry queue for the execute side.
// ----------------------------------------------------------------------------
module cafu_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  cafu_pkg::in_item_t op_req,
	output cafu_pkg::dec_op_t  dec_op,
	output logic               dec_valid,
	input  logic               dec_take
);
	import cafu_pkg::*;

	dec_op_t    dec_in;
	dec_op_t    slot_q [QUEUE_DEPTH];
	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       push_ok;

	// undefined modes become a no-op
	always_comb begin
		dec_in.op         = (op_req.mode <= 5'(OP_ADDSP)) ? op_t'(op_req.mode) : OP_NOP;
		dec_in.acc        = op_req.acc;
		dec_in.value      = op_req.value;
		dec_in.bit_index  = op_req.bit_index;
		dec_in.accum_form = op_req.accum_form;
		dec_in.wide_base  = op_req.wide_base;
		dec_in.wide_value = op_req.wide_value;
	end

	assign full      = (count_q == 2'(QUEUE_DEPTH));
	assign dec_valid = (count_q != 2'd0);
	assign push_ok   = push && !full;
	assign dec_op    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_ptr_q] <= dec_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (dec_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push_ok, dec_take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/cafu_back.sv */
// ----------------------------------------------------------------------------
// cafu_back
// Executes decoded operations against the kept flag register and places each
// result in a two-entry output queue.
// ----------------------------------------------------------------------------
module cafu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cafu_pkg::dec_op_t   dec_op,
	input  logic                dec_valid,
	output logic                dec_take,
	output logic                empty,
	input  logic                pop,
	output cafu_pkg::out_item_t op_rsp
);
	import cafu_pkg::*;

	flags_t     flags_q;
	flags_t     nf;
	out_item_t  slot_q [QUEUE_DEPTH];
	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       out_full;
	logic       pop_ok;

	logic [7:0]  a;
	logic [7:0]  v;
	logic [7:0]  res;
	logic [15:0] wres;
	logic        add_ci;
	logic        sub_ci;
	logic [8:0]  add9;
	logic [4:0]  add5;
	logic [7:0]  diff8;
	logic        sub_h;
	logic        sub_c;
	logic [16:0] sum17;
	logic [12:0] sum13;
	logic [15:0] sp_sum;
	logic [4:0]  sp5;
	logic [8:0]  sp9;
	logic        daa_lo;
	logic        daa_hi;
	logic [7:0]  daa_adj;

	assign a      = dec_op.acc;
	assign v      = dec_op.value;
	assign add_ci = (dec_op.op == OP_ADC) && flags_q.carry;
	assign sub_ci = (dec_op.op == OP_SBC) && flags_q.carry;
	assign add9   = {1'b0, a} + {1'b0, v} + {8'd0, add_ci};
	assign add5   = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, add_ci};
	assign diff8  = a - v - {7'd0, sub_ci};
	assign sub_h  = ({1'b0, v[3:0]} + {4'd0, sub_ci}) > {1'b0, a[3:0]};
	assign sub_c  = ({1'b0, v} + {8'd0, sub_ci}) > {1'b0, a};
	assign sum17  = {1'b0, dec_op.wide_base} + {1'b0, dec_op.wide_value};
	assign sum13  = {1'b0, dec_op.wide_base[11:0]} + {1'b0, dec_op.wide_value[11:0]};
	assign sp_sum = dec_op.wide_base + {{8{v[7]}}, v};
	assign sp5    = {1'b0, dec_op.wide_base[3:0]} + {1'b0, v[3:0]};
	assign sp9    = {1'b0, dec_op.wide_base[7:0]} + {1'b0, v};

	// decimal adjust: after a subtract only the recorded carries matter
	assign daa_lo  = flags_q.half || (!flags_q.subtract && (a[3:0] > 4'h9));
	assign daa_hi  = flags_q.carry || (!flags_q.subtract && (a > 8'h99));
	assign daa_adj = (daa_hi ? 8'h60 : 8'h00) | (daa_lo ? 8'h06 : 8'h00);

	always_comb begin
		res  = a;
		wres = 16'd0;
		nf   = flags_q;
		unique case (dec_op.op)
			OP_ADD, OP_ADC: begin
				res = add9[7:0];
				nf  = '{zero: (add9[7:0] == 8'd0), subtract: 1'b0,
					half: add5[4], carry: add9[8]};
			end
			OP_SUB, OP_SBC, OP_CP: begin
				if (dec_op.op != OP_CP) begin
					res = diff8;
				end
				nf = '{zero: (diff8 == 8'd0), subtract: 1'b1, half: sub_h, carry: sub_c};
			end
			OP_AND: begin
				res = a & v;
				nf  = '{zero: ((a & v) == 8'd0), subtract: 1'b0, half: 1'b1, carry: 1'b0};
			end
			OP_XOR: begin
				res = a ^ v;
				nf  = '{zero: ((a ^ v) == 8'd0), subtract: 1'b0, half: 1'b0, carry: 1'b0};
			end
			OP_OR: begin
				res = a | v;
				nf  = '{zero: ((a | v) == 8'd0), subtract: 1'b0, half: 1'b0, carry: 1'b0};
			end
			OP_INC: begin
				res = a + 8'd1;
				nf  = '{zero: (a == 8'hFF), subtract: 1'b0, half: (a[3:0] == 4'hF),
					carry: flags_q.carry};
			end
			OP_DEC: begin
				res = a - 8'd1;
				nf  = '{zero: (a == 8'h01), subtract: 1'b1, half: (a[3:0] == 4'h0),
					carry: flags_q.carry};
			end
			OP_RLC, OP_RL: begin
				res = {a[6:0], (dec_op.op == OP_RLC) ? a[7] : flags_q.carry};
				nf  = '{zero: !dec_op.accum_form && (res == 8'd0), subtract: 1'b0,
					half: 1'b0, carry: a[7]};
			end
			OP_RRC, OP_RR: begin
				res = {(dec_op.op == OP_RRC) ? a[0] : flags_q.carry, a[7:1]};
				nf  = '{zero: !dec_op.accum_form && (res == 8'd0), subtract: 1'b0,
					half: 1'b0, carry: a[0]};
			end
			OP_SLA: begin
				res = {a[6:0], 1'b0};
				nf  = '{zero: (a[6:0] == 7'd0), subtract: 1'b0, half: 1'b0, carry: a[7]};
			end
			OP_SRA: begin
				res = {a[7], a[7:1]};
				nf  = '{zero: (a[7:1] == 7'd0), subtract: 1'b0, half: 1'b0, carry: a[0]};
			end
			OP_SWAP: begin
				res = {a[3:0], a[7:4]};
				nf  = '{zero: (a == 8'd0), subtract: 1'b0, half: 1'b0, carry: 1'b0};
			end
			OP_SRL: begin
				res = {1'b0, a[7:1]};
				nf  = '{zero: (a[7:1] == 7'd0), subtract: 1'b0, half: 1'b0, carry: a[0]};
			end
			OP_BIT: begin
				nf = '{zero: !a[dec_op.bit_index], subtract: 1'b0, half: 1'b1,
					carry: flags_q.carry};
			end
			OP_DAA: begin
				res = flags_q.subtract ? (a - daa_adj) : (a + daa_adj);
				nf  = '{zero: (res == 8'd0), subtract: flags_q.subtract, half: 1'b0,
					carry: flags_q.subtract ? flags_q.carry : daa_hi};
			end
			OP_CPL: begin
				res = ~a;
				nf  = '{zero: flags_q.zero, subtract: 1'b1, half: 1'b1,
					carry: flags_q.carry};
			end
			OP_SCF: begin
				nf = '{zero: flags_q.zero, subtract: 1'b0, half: 1'b0, carry: 1'b1};
			end
			OP_CCF: begin
				nf = '{zero: flags_q.zero, subtract: 1'b0, half: 1'b0,
					carry: !flags_q.carry};
			end
			OP_ADD16: begin
				res  = 8'd0;
				wres = sum17[15:0];
				nf   = '{zero: flags_q.zero, subtract: 1'b0, half: sum13[12],
					carry: sum17[16]};
			end
			OP_ADDSP: begin
				res  = 8'd0;
				wres = sp_sum;
				nf   = '{zero: 1'b0, subtract: 1'b0, half: sp5[4], carry: sp9[8]};
			end
			default: begin
				res  = a;
				wres = 16'd0;
				nf   = flags_q;
			end
		endcase
	end

	assign out_full = (count_q == 2'(QUEUE_DEPTH));
	assign empty    = (count_q == 2'd0);
	assign dec_take = dec_valid && !out_full;
	assign pop_ok   = pop && !empty;
	assign op_rsp   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (dec_take) begin
			slot_q[wr_ptr_q] <= '{result: res, wide_result: wres, zero_out: nf.zero,
				subtract_out: nf.subtract, half_out: nf.half, carry_out: nf.carry};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= '0;
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (dec_take) begin
				flags_q  <= nf;
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({dec_take, pop_ok})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/cpu_alu_with_flags_unit.sv */
// Eight-bit ALU with a kept Z/N/H/C flag register. It takes one request per cycle
// while not full and returns one response per request, in order. A request into an
// idle block is registered in the decode queue and then in the output queue. The
// front decodes the mode into a two-entry queue; the back executes one operation per
// cycle while its output queue has room, against the flag register, which it updates
// in the same cycle, and writes a two-entry output queue. Either side may stall without
// stopping the other until its queue fills. Modes 25 to 31 return acc with the flags unchanged.
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_unit
// Top level: queue-style request and response ports around the decode front
// and the execute back.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  cafu_pkg::in_item_t  op_req,
	output logic                empty,
	input  logic                pop,
	output cafu_pkg::out_item_t op_rsp
);
	import cafu_pkg::*;

	dec_op_t dec_op;
	dec_hs_t dec_hs;

	cafu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.op_req    (op_req),
		.dec_op    (dec_op),
		.dec_valid (dec_hs.valid),
		.dec_take  (dec_hs.take)
	);

	cafu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dec_op    (dec_op),
		.dec_valid (dec_hs.valid),
		.dec_take  (dec_hs.take),
		.empty     (empty),
		.pop       (pop),
		.op_rsp    (op_rsp)
	);

	// back never takes from an empty decode queue
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dec_hs.take |-> dec_hs.valid)
		else $error("decode queue read while empty");

	// a request into an empty decode queue is visible next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !dec_hs.valid) |=> dec_hs.valid)
		else $error("accepted request not in decode queue");

	// an executed operation is waiting in the output queue next cycle
	a_take_lands: assert property (@(posedge clk) disable iff (!arst_n)
		dec_hs.take |=> !empty)
		else $error("executed operation missing from output queue");

endmodule
